@@ rtl/floor_step_motion_controller_core_defines.svh @@
// Assertion macros for the floor step motion controller.
`ifndef FLOOR_STEP_MOTION_CONTROLLER_CORE_DEFINES_SVH
`define FLOOR_STEP_MOTION_CONTROLLER_CORE_DEFINES_SVH
`ifndef SYNTH
// Check a property on aclk, skipped while aresetn is low.
`define FSMC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("fsmc assertion failed");
// Check a property on aclk, in reset as well.
`define FSMC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("fsmc assertion failed");
`else
`define FSMC_ASSERT(lbl, prop)
`define FSMC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ rtl/fsmc_pkg.sv @@
// Types and codes shared by the floor step motion controller.
`timescale 1ns / 1ps

package fsmc_pkg;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_UP      = 5'b00010,
        ST_DOWN    = 5'b00100,
        ST_ARRIVED = 5'b01000,
        ST_ERROR   = 5'b10000
    } state_t;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_UP      = 3'd1;
    localparam logic [2:0] MODE_DOWN    = 3'd2;
    localparam logic [2:0] MODE_ARRIVED = 3'd3;
    localparam logic [2:0] MODE_ERROR   = 3'd4;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_UP   = 2'd1;
    localparam logic [1:0] CMD_DOWN = 2'd2;
    localparam logic [1:0] CMD_STOP = 2'd3;

    localparam logic [1:0] CFG_PULSES_PER_FLOOR  = 2'd0;
    localparam logic [1:0] CFG_STEP_TIMEOUT_MS   = 2'd1;
    localparam logic [1:0] CFG_UP_TIMEOUT_ENABLE = 2'd2;

    localparam logic [19:0] PULSES_PER_FLOOR_RST = 20'd1000;
    localparam logic [15:0] STEP_TIMEOUT_MS_RST  = 16'd5000;

    typedef struct packed {
        logic [19:0] pulses_per_floor;
        logic [15:0] step_timeout_ms;
        logic        up_timeout_enable;
    } cfg_t;

    typedef struct packed {
        logic               request_pending;
        logic [3:0]         next_target;
        logic signed [31:0] pulse_count;
        logic [31:0]        now_ms;
    } item_t;

    typedef struct packed {
        state_t      state;
        logic [3:0]  cur_floor;
        logic [3:0]  tgt_floor;
        logic [31:0] start_pulse;
        logic [31:0] start_time;
    } ctl_t;

    typedef struct packed {
        logic [1:0] motor_cmd;
        logic [3:0] lamp_on_floor;
        logic [3:0] lamp_off_floor;
        logic [3:0] tone_floor;
        logic [3:0] clear_request_floor;
        logic       timed_out;
        logic [2:0] mode_now;
        logic [3:0] floor_now;
    } result_t;

    function automatic logic [2:0] mode_code(state_t st);
        logic [2:0] code;
        unique case (st)
            ST_IDLE:    code = MODE_IDLE;
            ST_UP:      code = MODE_UP;
            ST_DOWN:    code = MODE_DOWN;
            ST_ARRIVED: code = MODE_ARRIVED;
            ST_ERROR:   code = MODE_ERROR;
            default:    code = MODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/floor_step_motion_controller_core.sv @@
// Top level of the floor step motion controller: registers, handshake, config.
//
// channel  direction  handshake             payload
// s_       in         s_tvalid / s_tready   s_tdata[71:0]: one control tick
// m_       out        m_tvalid / m_tready   m_tdata[31:0]: one result per tick
// cfg_     in         cfg_wr_en             cfg_addr, cfg_wdata[19:0]
//
// Each item passes through the input register and then the output register;
// one item per cycle is sustained while the m_ side does not stall, with the
// combinational tick logic between the two registers. The controller state updates when an item
// moves from the input register to the output register. A stalled m_ side
// holds the result, and s_tready drops once the input register is also full.
// Reset is synchronous and active low; no clearing pass.
`timescale 1ns / 1ps
`include "floor_step_motion_controller_core_defines.svh"

module floor_step_motion_controller_core #(
    parameter int FLOOR_COUNT = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // request_pending, next_target[3:0], pulse_count[31:0], now_ms[31:0], zero pad
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // motor_cmd[1:0], lamp_on_floor[3:0], lamp_off_floor[3:0], tone_floor[3:0],
    // clear_request_floor[3:0], timed_out, mode_now[2:0], floor_now[3:0], zero pad
    output logic [31:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [19:0] cfg_wdata
);
    import fsmc_pkg::*;

    localparam logic [3:0] FLOOR_MAX = 4'(FLOOR_COUNT);

    cfg_t    cfg_reg;
    item_t   in_reg;
    logic    in_valid_reg;
    ctl_t    ctl_reg;
    ctl_t    ctl_next;
    result_t res_next;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulses_per_floor  <= PULSES_PER_FLOOR_RST;
            cfg_reg.step_timeout_ms   <= STEP_TIMEOUT_MS_RST;
            cfg_reg.up_timeout_enable <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_PULSES_PER_FLOOR:  cfg_reg.pulses_per_floor  <= cfg_wdata;
                CFG_STEP_TIMEOUT_MS:   cfg_reg.step_timeout_ms   <= cfg_wdata[15:0];
                CFG_UP_TIMEOUT_ENABLE: cfg_reg.up_timeout_enable <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.request_pending <= s_tdata[0];
            in_reg.next_target     <= s_tdata[4:1];
            in_reg.pulse_count     <= $signed(s_tdata[36:5]);
            in_reg.now_ms          <= s_tdata[68:37];
        end
    end

    fsmc_step_logic #(
        .FLOOR_COUNT(FLOOR_COUNT)
    ) u_step (
        .cfg     (cfg_reg),
        .ctl     (ctl_reg),
        .item    (in_reg),
        .ctl_next(ctl_next),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.state       <= ST_IDLE;
            ctl_reg.cur_floor   <= 4'd1;
            ctl_reg.tgt_floor   <= 4'd1;
            ctl_reg.start_pulse <= '0;
            ctl_reg.start_time  <= '0;
        end else if (advance) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       out_reg.floor_now,
                       out_reg.mode_now,
                       out_reg.timed_out,
                       out_reg.clear_request_floor,
                       out_reg.tone_floor,
                       out_reg.lamp_off_floor,
                       out_reg.lamp_on_floor,
                       out_reg.motor_cmd};

    `FSMC_ASSERT(a_in_hold, (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_reg)))
    `FSMC_ASSERT(a_ctl_hold, (!advance) |=> $stable(ctl_reg))
    `FSMC_ASSERT(a_arrive_idle, (advance && ctl_reg.state == ST_ARRIVED) |=>
                 (ctl_reg.state == ST_IDLE && $stable(ctl_reg.cur_floor)))
    `FSMC_ASSERT_ALWAYS(a_reset_empty, (!aresetn) |=> (!in_valid_reg && !out_valid_reg))
    `FSMC_ASSERT(a_floor_range, (ctl_reg.cur_floor != 4'd0) && (ctl_reg.cur_floor <= FLOOR_MAX))

endmodule

@@ rtl/fsmc_step_logic.sv @@
// Next-state and result logic for one control tick.
`timescale 1ns / 1ps

module fsmc_step_logic #(
    parameter int FLOOR_COUNT = 3
) (
    input  fsmc_pkg::cfg_t    cfg,
    input  fsmc_pkg::ctl_t    ctl,
    input  fsmc_pkg::item_t   item,
    output fsmc_pkg::ctl_t    ctl_next,
    output fsmc_pkg::result_t res
);
    import fsmc_pkg::*;

    localparam logic [3:0] FLOOR_MAX = 4'(FLOOR_COUNT);

    logic [31:0] pulse_u;
    logic [31:0] delta;
    logic [31:0] elapsed;
    logic        step_done;
    logic        step_late;
    logic        timeout_armed;
    logic [3:0]  tgt_clamp;
    logic [3:0]  floor_adv;

    assign pulse_u       = $unsigned(item.pulse_count);
    assign delta         = (ctl.state == ST_UP) ? (ctl.start_pulse - pulse_u)
                                                : (pulse_u - ctl.start_pulse);
    assign step_done     = !delta[31] && (delta >= {12'd0, cfg.pulses_per_floor});
    assign elapsed       = item.now_ms - ctl.start_time;
    assign step_late     = elapsed > {16'd0, cfg.step_timeout_ms};
    assign timeout_armed = (ctl.state == ST_DOWN) || cfg.up_timeout_enable;
    assign floor_adv     = (ctl.state == ST_UP) ? (ctl.cur_floor + 4'd1)
                                                : (ctl.cur_floor - 4'd1);

    always_comb begin
        priority if (item.next_target == 4'd0) begin
            tgt_clamp = 4'd1;
        end else if (item.next_target > FLOOR_MAX) begin
            tgt_clamp = FLOOR_MAX;
        end else begin
            tgt_clamp = item.next_target;
        end
    end

    always_comb begin
        ctl_next = ctl;
        res      = '0;
        unique case (ctl.state)
            ST_IDLE: begin
                if (item.request_pending) begin
                    ctl_next.tgt_floor = tgt_clamp;
                    res.lamp_on_floor  = tgt_clamp;
                    if (tgt_clamp == ctl.cur_floor) begin
                        ctl_next.state = ST_ARRIVED;
                    end else begin
                        ctl_next.start_pulse = pulse_u;
                        ctl_next.start_time  = item.now_ms;
                        if (tgt_clamp > ctl.cur_floor) begin
                            ctl_next.state = ST_UP;
                            res.motor_cmd  = CMD_UP;
                        end else begin
                            ctl_next.state = ST_DOWN;
                            res.motor_cmd  = CMD_DOWN;
                        end
                    end
                end
            end
            ST_UP, ST_DOWN: begin
                if (step_done) begin
                    ctl_next.cur_floor = floor_adv;
                    res.motor_cmd      = CMD_STOP;
                    if (floor_adv == ctl.tgt_floor) begin
                        ctl_next.state = ST_ARRIVED;
                    end else begin
                        ctl_next.start_pulse = pulse_u;
                        ctl_next.start_time  = item.now_ms;
                        if (ctl.tgt_floor > floor_adv) begin
                            ctl_next.state = ST_UP;
                            res.motor_cmd  = CMD_UP;
                        end else begin
                            ctl_next.state = ST_DOWN;
                            res.motor_cmd  = CMD_DOWN;
                        end
                    end
                end else if (timeout_armed && step_late) begin
                    ctl_next.state = ST_ERROR;
                    res.motor_cmd  = CMD_STOP;
                    res.timed_out  = 1'b1;
                end
            end
            ST_ARRIVED: begin
                res.lamp_off_floor      = ctl.tgt_floor;
                res.tone_floor          = ctl.tgt_floor;
                res.clear_request_floor = ctl.tgt_floor;
                ctl_next.state          = ST_IDLE;
            end
            ST_ERROR: begin
                res.clear_request_floor = ctl.tgt_floor;
                ctl_next.state          = ST_IDLE;
            end
            default: begin
                ctl_next.state = ST_IDLE;
            end
        endcase
        res.mode_now  = mode_code(ctl_next.state);
        res.floor_now = ctl_next.cur_floor;
    end

endmodule
